// File: rtl/swrr_pkg.sv
// shared types, constants and helper functions for the sticky weighted round robin picker
package swrr_pkg;

   localparam int SESSION_ENTRIES = 64;
   localparam int MAX_SERVERS     = 3;
   localparam int WEIGHT_REGS     = 3;
   localparam int PEER_CAP        = (MAX_SERVERS < WEIGHT_REGS) ? MAX_SERVERS : WEIGHT_REGS;

   localparam int KEY_W       = 32;
   localparam int SRV_W       = 2;
   localparam int WGT_W       = 8;
   localparam int CSR_W       = 8;
   localparam int IDX_W       = $clog2(SESSION_ENTRIES);
   localparam int CMP_W       = WGT_W + 1;
   localparam int DIV_CNT_W   = $clog2(WGT_W);

   typedef logic [WEIGHT_REGS-1:0][WGT_W-1:0] weight_array_type;

   typedef enum logic [1:0] {
      CSR_PEER_COUNT = 2'd0,
      CSR_WEIGHT0    = 2'd1,
      CSR_WEIGHT1    = 2'd2,
      CSR_WEIGHT2    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MOD,
      ST_SEARCH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [SRV_W-1:0] server;
   } entry_type;

   // zero weight counts as one
   function automatic logic [WGT_W-1:0] eff_weight(input logic [WGT_W-1:0] w);
      eff_weight = (w == '0) ? WGT_W'(1) : w;
   endfunction

   // peer count clamped to 1..PEER_CAP
   function automatic logic [SRV_W-1:0] peers_in_use(input logic [SRV_W-1:0] pc);
      logic [SRV_W-1:0] n;
      n = pc;
      if (n == '0) n = SRV_W'(1);
      if (n > SRV_W'(PEER_CAP)) n = SRV_W'(PEER_CAP);
      peers_in_use = n;
   endfunction

   function automatic logic [WGT_W-1:0] largest_weight(input logic [SRV_W-1:0] n,
                                                       input weight_array_type w);
      logic [WGT_W-1:0] m;
      m = WGT_W'(1);
      for (int s = 0; s < WEIGHT_REGS; s++) begin
         if (SRV_W'(s) < n && eff_weight(w[s]) > m) m = eff_weight(w[s]);
      end
      largest_weight = m;
   endfunction

   // cs mod n for a narrow cs and n of at least one
   function automatic logic [SRV_W-1:0] start_server(input logic [SRV_W-1:0] cs,
                                                     input logic [SRV_W-1:0] n);
      logic [SRV_W-1:0] r;
      r = cs;
      for (int k = 0; k < (1 << SRV_W) - 1; k++) begin
         if (r >= n) r = r - n;
      end
      start_server = r;
   endfunction

endpackage

// File: rtl/sticky_weighted_round_robin.sv
// sticky weighted round robin backend picker with a session table
//
// req_*: one word per flow, the client source address; accepted on req_valid & req_ready.
// rsp_*: one word per request: chosen server, whether it came from the session table,
//   and whether a new session could not be stored because the table is full.
// csr_*: register writes (peer count, three server weights), taken on any cycle with
//   csr_write_en high; write only while no request is in flight.
// One request at a time. The session table is scanned one entry per cycle through a
// registered memory read; a hit ends the scan at its entry. A miss then computes the
// round modulo the largest weight and runs a weight search that ends within one pass
// over the servers in use (at most 3), since the heaviest server beats every round;
// both run on one shared subtract/compare unit.
// req_ready goes low from acceptance until the cycle after the response word is taken,
// so a new request is not taken before the last one is answered. A stalled response
// simply holds in its output register.
// Reset empties the session table at once (valid bits), clears the round state and sets
// peer count and weights to one.
module sticky_weighted_round_robin (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [swrr_pkg::KEY_W-1:0]  req_source_ipv4,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [swrr_pkg::SRV_W-1:0]  rsp_server_index,
   output logic                        rsp_session_hit,
   output logic                        rsp_table_full,
   input  logic                        csr_write_en,
   input  swrr_pkg::csr_index_type     csr_index,
   input  logic [swrr_pkg::CSR_W-1:0]  csr_data
);
   import swrr_pkg::*;

   state_type                state_ff, state_in;
   logic [KEY_W-1:0]         key_ff, key_in;
   logic [IDX_W-1:0]         scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     chk_valid_ff, chk_valid_in;
   logic [SESSION_ENTRIES-1:0] valid_ff, valid_in;
   logic                     free_found_ff, free_found_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic [WGT_W-1:0]         rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic [WGT_W-1:0]         rnd_ff, rnd_in;
   logic [SRV_W-1:0]         srv_ff, srv_in;
   logic [SRV_W-1:0]         pos_ff, pos_in;
   logic [WGT_W-1:0]         cur_round_ff, cur_round_in;
   logic [SRV_W-1:0]         cur_server_ff, cur_server_in;
   logic [SRV_W-1:0]         peer_count_ff;
   weight_array_type         weight_ff;
   logic [SRV_W-1:0]         rsp_server_ff, rsp_server_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic                     rsp_full_ff, rsp_full_in;

   entry_type                mem [SESSION_ENTRIES];
   entry_type                mem_rd_ff;
   logic                     mem_we;

   logic [SRV_W-1:0]         peers;
   logic [WGT_W-1:0]         lw;
   logic [SRV_W-1:0]         s0;
   logic [WGT_W-1:0]         srv_weight;
   logic [WGT_W-1:0]         rnd_next;

   // shared subtract/compare unit
   logic [CMP_W-1:0]         alu_a, alu_b;
   logic [CMP_W:0]           alu_diff;
   logic                     alu_ge;

   assign peers      = peers_in_use(peer_count_ff);
   assign lw         = largest_weight(peers, weight_ff);
   assign s0         = start_server(cur_server_ff, peers);
   assign srv_weight = (srv_ff < SRV_W'(WEIGHT_REGS)) ? eff_weight(weight_ff[srv_ff])
                                                      : WGT_W'(1);
   assign rnd_next   = rnd_ff + WGT_W'(1);
   assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge     = !alu_diff[CMP_W];

   assign req_ready        = (state_ff == ST_IDLE) && !reset;
   assign rsp_valid        = (state_ff == ST_RESP) && !reset;
   assign rsp_server_index = rsp_server_ff;
   assign rsp_session_hit  = rsp_hit_ff;
   assign rsp_table_full   = rsp_full_ff;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      scan_ptr_in   = scan_ptr_ff;
      chk_idx_in    = chk_idx_ff;
      chk_valid_in  = chk_valid_ff;
      valid_in      = valid_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      rnd_in        = rnd_ff;
      srv_in        = srv_ff;
      pos_in        = pos_ff;
      cur_round_in  = cur_round_ff;
      cur_server_in = cur_server_ff;
      rsp_server_in = rsp_server_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_full_in   = rsp_full_ff;
      alu_a         = '0;
      alu_b         = '0;
      mem_we        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               key_in        = req_source_ipv4;
               scan_ptr_in   = '0;
               chk_valid_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read entry scan_ptr, check the entry read last cycle
            scan_ptr_in  = scan_ptr_ff + IDX_W'(1);
            chk_idx_in   = scan_ptr_ff;
            chk_valid_in = 1'b1;
            if (chk_valid_ff) begin
               if (valid_ff[chk_idx_ff] && mem_rd_ff.key == key_ff) begin
                  rsp_server_in = mem_rd_ff.server;
                  rsp_hit_in    = 1'b1;
                  rsp_full_in   = 1'b0;
                  state_in      = ST_RESP;
               end else begin
                  if (!valid_ff[chk_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
                  if (chk_idx_ff == IDX_W'(SESSION_ENTRIES - 1)) begin
                     rem_in     = '0;
                     div_cnt_in = DIV_CNT_W'(WGT_W - 1);
                     state_in   = ST_MOD;
                  end
               end
            end
         end
         ST_MOD: begin
            // restoring remainder, one bit of current round per cycle
            alu_a      = {rem_ff, cur_round_ff[div_cnt_ff]};
            alu_b      = {1'b0, lw};
            rem_in     = alu_ge ? alu_diff[WGT_W-1:0] : alu_a[WGT_W-1:0];
            div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
            if (div_cnt_ff == '0) begin
               rnd_in   = rem_in;
               srv_in   = s0;
               pos_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // weight > round is the same as not (round >= weight)
            alu_a = {1'b0, rnd_ff};
            alu_b = {1'b0, srv_weight};
            if (!alu_ge) begin
               rsp_server_in = srv_ff;
               rsp_hit_in    = 1'b0;
               rsp_full_in   = !free_found_ff;
               cur_round_in  = rnd_next;
               cur_server_in = srv_ff + SRV_W'(1);
               if (free_found_ff) begin
                  mem_we                = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
               end
               state_in = ST_RESP;
            end else if (pos_ff == peers - SRV_W'(1)) begin
               pos_in = '0;
               srv_in = s0;
               rnd_in = (rnd_next == lw) ? '0 : rnd_next;
            end else begin
               pos_in = pos_ff + SRV_W'(1);
               srv_in = (srv_ff + SRV_W'(1) == peers) ? '0 : srv_ff + SRV_W'(1);
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         free_found_ff <= 1'b0;
         cur_round_ff  <= '0;
         cur_server_ff <= '0;
         peer_count_ff <= SRV_W'(1);
         for (int s = 0; s < WEIGHT_REGS; s++) begin
            weight_ff[s] <= WGT_W'(1);
         end
      end else begin
         state_ff      <= state_in;
         chk_valid_ff  <= chk_valid_in;
         valid_ff      <= valid_in;
         free_found_ff <= free_found_in;
         cur_round_ff  <= cur_round_in;
         cur_server_ff <= cur_server_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_PEER_COUNT: peer_count_ff <= csr_data[SRV_W-1:0];
               CSR_WEIGHT0:    weight_ff[0]  <= csr_data[WGT_W-1:0];
               CSR_WEIGHT1:    weight_ff[1]  <= csr_data[WGT_W-1:0];
               CSR_WEIGHT2:    weight_ff[2]  <= csr_data[WGT_W-1:0];
               default:        peer_count_ff <= peer_count_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      scan_ptr_ff   <= scan_ptr_in;
      chk_idx_ff    <= chk_idx_in;
      free_idx_ff   <= free_idx_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      rnd_ff        <= rnd_in;
      srv_ff        <= srv_in;
      pos_ff        <= pos_in;
      rsp_server_ff <= rsp_server_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_full_ff   <= rsp_full_in;
   end

   // session table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= '{key: key_ff, server: srv_ff};
      end
      mem_rd_ff <= mem[scan_ptr_ff];
   end

endmodule

// File: rtl/swrr_checker.sv
// port-level checks for the sticky weighted round robin picker, bound to its top level
module swrr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_server_index,
   input logic       rsp_session_hit,
   input logic       rsp_table_full
);

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_server_index)
         && $stable(rsp_session_hit) && $stable(rsp_table_full))
      else $error("response word changed while stalled");

   // one request in flight: no new request while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   // the table scan runs before any response is given
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("response or new request right after acceptance");

   // a session hit never reports a full table
   a_hit_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_session_hit |-> !rsp_table_full)
      else $error("hit flagged with table full");

   // chosen server indexes are always among the three weight registers (0 to 2)
   a_server_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_server_index != 2'd3)
      else $error("server index out of range");

endmodule

bind sticky_weighted_round_robin swrr_checker u_swrr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_server_index (rsp_server_index),
   .rsp_session_hit  (rsp_session_hit),
   .rsp_table_full   (rsp_table_full)
);
